@@ src/cbfd_pkg.sv @@
// ----------------------------------------------------------------------------
// cbfd_pkg: shared types and constants of the battery frame decoder
// Frame identifiers, signal indexes, frame kinds and the per-lane result word.
// ----------------------------------------------------------------------------
package cbfd_pkg;

  localparam int unsigned LANE_COUNT = 4;

  localparam logic [31:0] ID_CELLS_A = 32'd2281734144;
  localparam logic [31:0] ID_CELLS_B = 32'd2281799680;
  localparam logic [31:0] ID_CELLS_C = 32'd2281865216;
  localparam logic [31:0] ID_CELLS_D = 32'd2281930752;
  localparam logic [31:0] ID_PACK    = 32'd2214625280;
  localparam logic [31:0] ID_TEMPS   = 32'd2415951872;
  localparam logic [31:0] ID_CHARGE  = 32'd2214756352;

  localparam logic [4:0] IDX_PACK_VOLTS = 5'd16;
  localparam logic [4:0] IDX_CURRENT    = 5'd17;
  localparam logic [4:0] IDX_TEMP_BASE  = 5'd18;
  localparam logic [4:0] IDX_CHARGE     = 5'd22;

  localparam logic [1:0] CFG_CURRENT_OFFSET     = 2'd0;
  localparam logic [1:0] CFG_TEMPERATURE_OFFSET = 2'd1;

  localparam logic [3:0] MAX_LENGTH = 4'd8;
  localparam logic [3:0] CHARGE_MIN_LENGTH = 4'd7;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_CELLS,
    KIND_PACK,
    KIND_TEMPS,
    KIND_CHARGE
  } frame_kind_t;

  // Kind of frame plus the group of four cells for cell frames.
  typedef struct packed {
    frame_kind_t kind;
    logic [1:0]  cell_group;
  } frame_class_t;

  typedef logic [7:0][7:0] frame_data_t;

  typedef struct packed {
    logic        valid;
    logic [4:0]  index;
    logic [17:0] value;
  } lane_result_t;

endpackage

@@ src/cbfd_lane.sv @@
// ----------------------------------------------------------------------------
// cbfd_lane: one decoding lane
// Works out the signal that a given slot of the frame carries, if any.
// ----------------------------------------------------------------------------
module cbfd_lane import cbfd_pkg::*; (
  input  logic [1:0]   lane,
  input  frame_class_t frame_class,
  input  logic [3:0]   length,
  input  frame_data_t  data,
  input  logic [15:0]  current_offset,
  input  logic [7:0]   temperature_offset,
  output lane_result_t result
);

  logic [2:0]  pos;
  logic [2:0]  pos_lo;
  logic [7:0]  lo_byte;
  logic [15:0] word;
  logic        word_in_frame;

  // Cell and pack frames both carry a big-endian word at twice the lane number.
  assign pos           = {lane, 1'b0};
  assign pos_lo        = {lane, 1'b1};
  assign lo_byte       = ({1'b0, pos_lo} < length) ? data[pos_lo] : 8'd0;
  assign word          = {data[pos], lo_byte};
  assign word_in_frame = {1'b0, pos} < length;

  always_comb begin
    result.valid = 1'b0;
    result.index = 5'd0;
    result.value = 18'd0;
    unique case (frame_class.kind)
      KIND_CELLS: begin
        result.valid = word_in_frame;
        result.index = {1'b0, frame_class.cell_group, lane};
        result.value = {2'b00, word};
      end
      KIND_PACK: begin
        if (lane == 2'd0) begin
          result.valid = word_in_frame;
          result.index = IDX_PACK_VOLTS;
          result.value = {2'b00, word};
        end else if (lane == 2'd1) begin
          result.valid = word_in_frame;
          result.index = IDX_CURRENT;
          result.value = {2'b00, word} - {2'b00, current_offset};
        end
      end
      KIND_TEMPS: begin
        result.valid = {2'b00, lane} < length;
        result.index = IDX_TEMP_BASE + {3'b000, lane};
        result.value = {10'd0, data[lane]} - {10'd0, temperature_offset};
      end
      KIND_CHARGE: begin
        result.valid = (lane == 2'd0) && (length >= CHARGE_MIN_LENGTH);
        result.index = IDX_CHARGE;
        result.value = {2'b00, data[5], data[6]};
      end
      default: begin
        result.valid = 1'b0;
      end
    endcase
  end

endmodule

@@ src/cbfd_merge.sv @@
// ----------------------------------------------------------------------------
// cbfd_merge: result merging and signal store
// Holds one frame's lane results and sends them out one word a cycle unless
// signal_stall holds them, comparing each to its stored value and updating it.
// ----------------------------------------------------------------------------
module cbfd_merge import cbfd_pkg::*; #(
  parameter int SIGNAL_COUNT = 23
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               frame_valid,
  output logic               frame_stall,
  input  lane_result_t [LANE_COUNT-1:0] lanes,
  output logic               signal_valid,
  input  logic               signal_stall,
  output logic [4:0]         signal_index,
  output logic signed [16:0] signal_value,
  output logic               value_changed,
  output logic               last_of_frame
);

  localparam int IW = $clog2(SIGNAL_COUNT);

  lane_result_t [LANE_COUNT-1:0] slot;
  logic                          slot_valid;
  logic [2:0]                    slot_count;
  logic [1:0]                    ptr;
  logic [17:0]                   store [SIGNAL_COUNT];

  logic [2:0]   count_in;
  logic         out_free;
  logic         pop;
  logic         last;
  logic         accept;
  lane_result_t cur;
  logic         in_range;
  logic         changed;

  // Valid lanes always form a run from lane zero, so the count alone marks them.
  always_comb begin
    count_in = 3'd0;
    for (int i = 0; i < LANE_COUNT; i++) begin
      count_in = count_in + {2'b00, lanes[i].valid};
    end
  end

  assign out_free    = !signal_valid || !signal_stall;
  assign pop         = slot_valid && out_free;
  assign last        = {1'b0, ptr} == (slot_count - 3'd1);
  assign frame_stall = slot_valid && !(pop && last);
  assign accept      = frame_valid && !frame_stall;

  assign cur      = slot[ptr];
  assign in_range = {1'b0, cur.index} < 6'(SIGNAL_COUNT);
  assign changed  = in_range && (store[cur.index[IW-1:0]] != cur.value);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid   <= 1'b0;
      ptr          <= 2'd0;
      signal_valid <= 1'b0;
      for (int i = 0; i < SIGNAL_COUNT; i++) begin
        store[i] <= 18'd0;
      end
    end else begin
      if (accept) begin
        slot_valid <= count_in != 3'd0;
        slot_count <= count_in;
        slot       <= lanes;
        ptr        <= 2'd0;
      end else if (pop) begin
        // The slot empties once its final word has gone out.
        if (last) begin
          slot_valid <= 1'b0;
        end
        ptr <= ptr + 2'd1;
      end

      if (pop) begin
        signal_valid  <= 1'b1;
        signal_index  <= cur.index;
        signal_value  <= cur.value[16:0];
        value_changed <= changed;
        last_of_frame <= last;
        if (in_range) begin
          store[cur.index[IW-1:0]] <= cur.value;
        end
      end else if (!signal_stall) begin
        signal_valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/can_battery_frame_decoder_top.sv @@
// ----------------------------------------------------------------------------
// can_battery_frame_decoder_top: battery CAN frame decoder
// Decodes one CAN frame per word into up to four battery signal words.
// ----------------------------------------------------------------------------
// Pipeline: a frame's lane results are registered in a slot on acceptance,
// and each result word is registered again at the output.
// Throughput: one result word per cycle unless signal_stall holds the output;
// a frame gives up to four words, and a frame giving none fills no slot.
// Reset: synchronous rst empties the pipeline, zeroes the signal store and
// returns the offsets to 30000 and 40.
module can_battery_frame_decoder_top import cbfd_pkg::*; #(
  parameter int SIGNAL_COUNT = 23
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               frame_valid,
  output logic               frame_stall,
  input  logic [31:0]        frame_id,
  input  logic [3:0]         payload_length,
  input  logic [7:0]         data_byte_0,
  input  logic [7:0]         data_byte_1,
  input  logic [7:0]         data_byte_2,
  input  logic [7:0]         data_byte_3,
  input  logic [7:0]         data_byte_4,
  input  logic [7:0]         data_byte_5,
  input  logic [7:0]         data_byte_6,
  input  logic [7:0]         data_byte_7,
  output logic               signal_valid,
  input  logic               signal_stall,
  output logic [4:0]         signal_index,
  output logic signed [16:0] signal_value,
  output logic               value_changed,
  output logic               last_of_frame
);

  logic [15:0]  current_offset;
  logic [7:0]   temperature_offset;
  frame_class_t frame_class;
  logic [3:0]   length;
  frame_data_t  data;
  lane_result_t [LANE_COUNT-1:0] lanes;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_offset     <= 16'd30000;
      temperature_offset <= 8'd40;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_CURRENT_OFFSET) begin
        current_offset <= cfg_data;
      end else if (cfg_index == CFG_TEMPERATURE_OFFSET) begin
        temperature_offset <= cfg_data[7:0];
      end
    end
  end

  always_comb begin
    frame_class.kind       = KIND_NONE;
    frame_class.cell_group = 2'd0;
    if (frame_id == ID_CELLS_A) begin
      frame_class.kind = KIND_CELLS;
    end else if (frame_id == ID_CELLS_B) begin
      frame_class.kind       = KIND_CELLS;
      frame_class.cell_group = 2'd1;
    end else if (frame_id == ID_CELLS_C) begin
      frame_class.kind       = KIND_CELLS;
      frame_class.cell_group = 2'd2;
    end else if (frame_id == ID_CELLS_D) begin
      frame_class.kind       = KIND_CELLS;
      frame_class.cell_group = 2'd3;
    end else if (frame_id == ID_PACK) begin
      frame_class.kind = KIND_PACK;
    end else if (frame_id == ID_TEMPS) begin
      frame_class.kind = KIND_TEMPS;
    end else if (frame_id == ID_CHARGE) begin
      frame_class.kind = KIND_CHARGE;
    end
  end

  assign length = (payload_length > MAX_LENGTH) ? MAX_LENGTH : payload_length;
  assign data   = {data_byte_7, data_byte_6, data_byte_5, data_byte_4,
                   data_byte_3, data_byte_2, data_byte_1, data_byte_0};

  for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
    cbfd_lane u_lane (
      .lane               (2'(g)),
      .frame_class        (frame_class),
      .length             (length),
      .data               (data),
      .current_offset     (current_offset),
      .temperature_offset (temperature_offset),
      .result             (lanes[g])
    );
  end

  cbfd_merge #(
    .SIGNAL_COUNT (SIGNAL_COUNT)
  ) u_merge (
    .clk           (clk),
    .rst           (rst),
    .frame_valid   (frame_valid),
    .frame_stall   (frame_stall),
    .lanes         (lanes),
    .signal_valid  (signal_valid),
    .signal_stall  (signal_stall),
    .signal_index  (signal_index),
    .signal_value  (signal_value),
    .value_changed (value_changed),
    .last_of_frame (last_of_frame)
  );

endmodule
